/* rtl/fbds_pkg.sv */
// ----------------------------------------------------------------------------
// fbds_pkg
// shared types, constants and helpers of the changed-block span detector
// ----------------------------------------------------------------------------
`default_nettype none

package fbds_pkg;

   localparam int DEF_MAX_BLOCKS_H = 64;
   localparam int DEF_MAX_CELLS    = 1024;
   localparam int QUEUE_DEPTH      = 2;
   localparam int CSR_DATA_W       = 11;
   localparam int CSR_INDEX_W      = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_WIDTH_CELLS  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HEIGHT_CELLS = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BLOCK_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BLOCK_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_CELL_BYTES   = 3'd4;

   localparam logic [10:0] RST_WIDTH_CELLS  = 11'd320;
   localparam logic [10:0] RST_HEIGHT_CELLS = 11'd240;
   localparam logic [6:0]  RST_BLOCK_WIDTH  = 7'd8;
   localparam logic [6:0]  RST_BLOCK_HEIGHT = 7'd8;
   localparam logic [2:0]  RST_CELL_BYTES   = 3'd2;

   typedef struct packed {
      logic [7:0] prev_byte;
      logic [7:0] curr_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [5:0]  span_col;
      logic [9:0]  span_row;
      logic [6:0]  span_blocks;
      logic [10:0] span_width;
      logic [6:0]  span_height;
      logic [18:0] payload_bytes;
      logic        frame_done;
      logic        last;
   } rsp_type;

   // clamped configuration
   typedef struct packed {
      logic [10:0] w;
      logic [10:0] h;
      logic [6:0]  bw;
      logic [6:0]  bh;
      logic [2:0]  cb;
   } cfg_type;

   // block row handed from front to back
   typedef struct packed {
      logic [10:0] w;
      logic [6:0]  bw;
      logic [2:0]  cb;
      logic [6:0]  rows;
      logic [9:0]  brow;
      logic        done;
   } row_info_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCAN,
      BK_MUL1,
      BK_MUL2,
      BK_PUSH,
      BK_FLUSH,
      BK_MARK
   } back_state_type;

   // zero counts as one, above hi counts as hi
   function automatic logic [15:0] clamp_fn(input logic [15:0] v, input logic [15:0] hi);
      logic [15:0] r;
      if (v == 16'd0) r = 16'd1;
      else if (v > hi) r = hi;
      else r = v;
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/fbds_front.sv */
// ----------------------------------------------------------------------------
// fbds_front
// raster position counters and per-column changed flags, one byte per cycle while the row queue is not full
// ----------------------------------------------------------------------------
`default_nettype none

module fbds_front import fbds_pkg::*; #(
   parameter int MAX_BLOCKS_H = DEF_MAX_BLOCKS_H,
   localparam int FW = (MAX_BLOCKS_H > 1) ? $clog2(MAX_BLOCKS_H) : 1
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cfg_type                 cfg,
   input  wire logic                    req_valid,
   input  wire req_type                 req_data,
   output logic                         req_stall,
   input  wire logic                    queue_full,
   output logic                         push,
   output logic [MAX_BLOCKS_H-1:0]      push_flags,
   output row_info_type                 push_info
);

   logic [MAX_BLOCKS_H-1:0] flags_ff, flags_in;
   logic [1:0]  bic_ff, bic_in;
   logic [10:0] cc_ff, cc_in, cr_ff, cr_in;
   logic [5:0]  cib_ff, cib_in, rib_ff, rib_in;
   logic [FW-1:0] bc_ff, bc_in;
   logic [9:0]  br_ff, br_in;
   logic        over_ff, over_in;

   logic accept;
   logic [MAX_BLOCKS_H-1:0] e_flags, set_flags;
   logic [1:0]  e_bic;
   logic [10:0] e_cc, e_cr;
   logic [5:0]  e_cib, e_rib;
   logic [FW-1:0] e_bc;
   logic [9:0]  e_br;
   logic        e_over, row_end, frame_end;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      // frame start clears position before the byte is used
      e_flags = req_data.frame_start ? '0 : flags_ff;
      e_bic   = req_data.frame_start ? '0 : bic_ff;
      e_cc    = req_data.frame_start ? '0 : cc_ff;
      e_cr    = req_data.frame_start ? '0 : cr_ff;
      e_cib   = req_data.frame_start ? '0 : cib_ff;
      e_rib   = req_data.frame_start ? '0 : rib_ff;
      e_bc    = req_data.frame_start ? '0 : bc_ff;
      e_br    = req_data.frame_start ? '0 : br_ff;
      e_over  = req_data.frame_start ? 1'b0 : over_ff;

      set_flags = e_flags;
      if (req_data.prev_byte != req_data.curr_byte) set_flags[e_bc] = 1'b1;

      flags_in = set_flags;
      bic_in = e_bic; cc_in = e_cc; cr_in = e_cr; cib_in = e_cib;
      rib_in = e_rib; bc_in = e_bc; br_in = e_br; over_in = e_over;
      row_end = 1'b0;
      frame_end = 1'b0;

      if (e_over) begin
         flags_in = e_flags;
      end else if ({1'b0, e_bic} + 3'd1 < cfg.cb) begin
         bic_in = e_bic + 2'd1;
      end else begin
         bic_in = '0;
         if ({1'b0, e_cib} + 7'd1 >= cfg.bw) begin
            cib_in = '0;
            if ({1'b0, e_bc} + (FW+1)'(1) < (FW+1)'(MAX_BLOCKS_H)) bc_in = e_bc + FW'(1);
         end else begin
            cib_in = e_cib + 6'd1;
         end
         if ({1'b0, e_cc} + 12'd1 < {1'b0, cfg.w}) begin
            cc_in = e_cc + 11'd1;
         end else begin
            cc_in = '0; cib_in = '0; bc_in = '0;
            frame_end = ({1'b0, e_cr} + 12'd1 >= {1'b0, cfg.h});
            row_end = ({1'b0, e_rib} + 7'd1 >= cfg.bh) || frame_end;
            if (row_end) begin
               flags_in = '0;
               rib_in = '0;
               br_in = e_br + 10'd1;
            end else begin
               rib_in = e_rib + 6'd1;
            end
            if (frame_end) begin
               cr_in = '0; rib_in = '0; br_in = '0; over_in = 1'b1;
            end else begin
               cr_in = e_cr + 11'd1;
            end
         end
      end

      push = accept && row_end && ((|set_flags) || frame_end);
      push_flags = set_flags;
      push_info.w    = cfg.w;
      push_info.bw   = cfg.bw;
      push_info.cb   = cfg.cb;
      push_info.rows = {1'b0, e_rib} + 7'd1;
      push_info.brow = e_br;
      push_info.done = frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0; bic_ff <= '0; cc_ff <= '0; cr_ff <= '0; cib_ff <= '0;
         rib_ff <= '0; bc_ff <= '0; br_ff <= '0; over_ff <= 1'b0;
      end else if (accept) begin
         flags_ff <= flags_in; bic_ff <= bic_in; cc_ff <= cc_in; cr_ff <= cr_in;
         cib_ff <= cib_in; rib_ff <= rib_in; bc_ff <= bc_in; br_ff <= br_in;
         over_ff <= over_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/fbds_queue.sv */
// ----------------------------------------------------------------------------
// fbds_queue
// short queue of finished block rows between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module fbds_queue import fbds_pkg::*; #(
   parameter int MAX_BLOCKS_H = DEF_MAX_BLOCKS_H,
   parameter int DEPTH = QUEUE_DEPTH,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire logic [MAX_BLOCKS_H-1:0] push_flags,
   input  wire row_info_type            push_info,
   input  wire logic                    pop,
   output logic                         full,
   output logic                         empty,
   output logic [MAX_BLOCKS_H-1:0]      head_flags,
   output row_info_type                 head_info
);

   logic [MAX_BLOCKS_H-1:0] flags_ff [DEPTH];
   row_info_type            info_ff  [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == (AW+1)'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign head_flags = flags_ff[rd_ff];
   assign head_info  = info_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + AW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + AW'(1);
      end
      if (push && !pop) cnt_in = cnt_ff + (AW+1)'(1);
      else if (!push && pop) cnt_in = cnt_ff - (AW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         flags_ff[wr_ff] <= push_flags;
         info_ff[wr_ff]  <= push_info;
      end
   end

endmodule

`default_nettype wire

/* rtl/fbds_back.sv */
// ----------------------------------------------------------------------------
// fbds_back
// walks the flags of one block row and emits the spans and frame marker
// ----------------------------------------------------------------------------
`default_nettype none

module fbds_back import fbds_pkg::*; #(
   parameter int MAX_BLOCKS_H = DEF_MAX_BLOCKS_H,
   localparam int FW = (MAX_BLOCKS_H > 1) ? $clog2(MAX_BLOCKS_H) : 1,
   localparam int IW = $clog2(MAX_BLOCKS_H + 1),
   localparam int PWR = $clog2(MAX_BLOCKS_H * 64 + 1),
   localparam int PW = (PWR > 12) ? PWR : 12
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    empty,
   input  wire logic [MAX_BLOCKS_H-1:0] head_flags,
   input  wire row_info_type            head_info,
   output logic                         pop,
   output logic                         rsp_valid,
   output rsp_type                      rsp_data,
   input  wire logic                    rsp_stall
);

   back_state_type state_ff, state_in;
   logic [IW-1:0] i_ff, i_in, scol_ff, scol_in;
   logic [PW-1:0] pos_ff, pos_in, spos_ff, spos_in;
   logic          inrun_ff, inrun_in, send_ff, send_in;
   logic [10:0]   sw_ff, sw_in;
   logic [IW-1:0] n_ff, n_in;
   logic [17:0]   prod_ff, prod_in;
   rsp_type       new_ff, new_in, pend_ff, pend_in;
   logic          pend_v_ff, pend_v_in;
   logic          out_v_ff, out_v_in;
   rsp_type       out_ff, out_in;

   logic          out_free, scan_end, flag;
   logic [PW-1:0] w_ext;
   logic [20:0]   pay;

   assign out_free  = !out_v_ff || !rsp_stall;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;
   assign w_ext     = PW'(head_info.w);
   assign scan_end  = (i_ff == IW'(MAX_BLOCKS_H)) || (pos_ff >= w_ext);
   assign flag      = head_flags[i_ff[FW-1:0]];
   assign pay       = prod_ff * head_info.cb;

   always_comb begin
      state_in = state_ff;
      i_in = i_ff; pos_in = pos_ff; scol_in = scol_ff; spos_in = spos_ff;
      inrun_in = inrun_ff; send_in = send_ff;
      sw_in = sw_ff; n_in = n_ff; prod_in = prod_ff;
      new_in = new_ff; pend_in = pend_ff; pend_v_in = pend_v_ff;
      out_v_in = out_free ? 1'b0 : out_v_ff;
      out_in = out_ff;
      pop = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (!empty) begin
               i_in = '0; pos_in = '0; inrun_in = 1'b0;
               state_in = BK_SCAN;
            end
         end
         BK_SCAN: begin
            if (scan_end) begin
               send_in = 1'b1;
               if (inrun_ff) begin
                  // run reaches the right edge
                  sw_in = 11'(w_ext - spos_ff);
                  n_in = i_ff - scol_ff;
                  inrun_in = 1'b0;
                  state_in = BK_MUL1;
               end else begin
                  state_in = BK_FLUSH;
               end
            end else begin
               send_in = 1'b0;
               i_in = i_ff + IW'(1);
               pos_in = pos_ff + PW'(head_info.bw);
               if (flag && !inrun_ff) begin
                  inrun_in = 1'b1;
                  scol_in = i_ff;
                  spos_in = pos_ff;
               end else if (!flag && inrun_ff) begin
                  sw_in = 11'(pos_ff - spos_ff);
                  n_in = i_ff - scol_ff;
                  inrun_in = 1'b0;
                  state_in = BK_MUL1;
               end
            end
         end
         BK_MUL1: begin
            prod_in = sw_ff * head_info.rows;
            state_in = BK_MUL2;
         end
         BK_MUL2: begin
            new_in.span_col      = 6'(scol_ff);
            new_in.span_row      = head_info.brow;
            new_in.span_blocks   = 7'(n_ff);
            new_in.span_width    = sw_ff;
            new_in.span_height   = head_info.rows;
            new_in.payload_bytes = pay[18:0];
            new_in.frame_done    = 1'b0;
            new_in.last          = 1'b0;
            state_in = BK_PUSH;
         end
         BK_PUSH: begin
            if (!pend_v_ff) begin
               pend_in = new_ff; pend_v_in = 1'b1;
               state_in = send_ff ? BK_FLUSH : BK_SCAN;
            end else if (out_free) begin
               out_in = pend_ff; out_v_in = 1'b1;
               pend_in = new_ff;
               state_in = send_ff ? BK_FLUSH : BK_SCAN;
            end
         end
         BK_FLUSH: begin
            if (pend_v_ff) begin
               if (out_free) begin
                  out_in = pend_ff;
                  out_in.last = !head_info.done;
                  out_v_in = 1'b1;
                  pend_v_in = 1'b0;
                  if (head_info.done) begin
                     state_in = BK_MARK;
                  end else begin
                     pop = 1'b1;
                     state_in = BK_IDLE;
                  end
               end
            end else if (head_info.done) begin
               state_in = BK_MARK;
            end else begin
               pop = 1'b1;
               state_in = BK_IDLE;
            end
         end
         BK_MARK: begin
            if (out_free) begin
               out_in = '0;
               out_in.frame_done = 1'b1;
               out_in.last = 1'b1;
               out_v_in = 1'b1;
               pop = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         pend_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
         inrun_ff <= 1'b0;
         send_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_v_ff <= pend_v_in;
         out_v_ff <= out_v_in;
         inrun_ff <= inrun_in;
         send_ff <= send_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in; pos_ff <= pos_in; scol_ff <= scol_in; spos_ff <= spos_in;
      sw_ff <= sw_in; n_ff <= n_in; prod_ff <= prod_in;
      new_ff <= new_in; pend_ff <= pend_in; out_ff <= out_in;
   end

endmodule

`default_nettype wire

/* rtl/frame_block_diff_spans.sv */
// ----------------------------------------------------------------------------
// frame_block_diff_spans
// changed-block span detector over a raster stream of frame byte pairs
// ----------------------------------------------------------------------------
// The block takes one previous/current byte pair per cycle, with no bubbles
// while the row queue has room. At the end of each block row with a changed
// block, and at frame end, changed flags and row geometry go into a two-entry
// queue; the back end walks the flags one block column per cycle, pausing at
// each span for the size and payload products and for output room, then
// hands spans and the frame-done marker out through a registered output. The
// input stalls only when both queue entries are taken, i.e. when span output
// falls more than a block row behind. Configuration writes take effect at once.
`default_nettype none

module frame_block_diff_spans import fbds_pkg::*; #(
   parameter int MAX_BLOCKS_H = DEF_MAX_BLOCKS_H,
   parameter int MAX_CELLS    = DEF_MAX_CELLS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // configuration
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   // input items
   input  wire logic                   req_valid,
   input  wire req_type                req_data,
   output logic                        req_stall,
   // result items
   output logic                        rsp_valid,
   output rsp_type                     rsp_data,
   input  wire logic                   rsp_stall
);

   // raw registers
   logic [10:0] width_ff, height_ff;
   logic [6:0]  bw_ff, bh_ff;
   logic [2:0]  cb_ff;
   cfg_type     cfg;

   // front to queue to back
   logic                    push, pop, full, empty;
   logic [MAX_BLOCKS_H-1:0] push_flags, head_flags;
   row_info_type            push_info, head_info;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_WIDTH_CELLS;
         height_ff <= RST_HEIGHT_CELLS;
         bw_ff     <= RST_BLOCK_WIDTH;
         bh_ff     <= RST_BLOCK_HEIGHT;
         cb_ff     <= RST_CELL_BYTES;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_WIDTH_CELLS:  width_ff  <= csr_data;
            REG_HEIGHT_CELLS: height_ff <= csr_data;
            REG_BLOCK_WIDTH:  bw_ff     <= csr_data[6:0];
            REG_BLOCK_HEIGHT: bh_ff     <= csr_data[6:0];
            REG_CELL_BYTES:   cb_ff     <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // out-of-range values are clamped
   always_comb begin
      cfg.w  = 11'(clamp_fn({5'd0, width_ff}, 16'(MAX_CELLS)));
      cfg.h  = 11'(clamp_fn({5'd0, height_ff}, 16'(MAX_CELLS)));
      cfg.bw = 7'(clamp_fn({9'd0, bw_ff}, 16'd64));
      cfg.bh = 7'(clamp_fn({9'd0, bh_ff}, 16'd64));
      cfg.cb = 3'(clamp_fn({13'd0, cb_ff}, 16'd4));
   end

   fbds_front #(.MAX_BLOCKS_H(MAX_BLOCKS_H)) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .queue_full (full),
      .push       (push),
      .push_flags (push_flags),
      .push_info  (push_info)
   );

   fbds_queue #(.MAX_BLOCKS_H(MAX_BLOCKS_H), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_flags (push_flags),
      .push_info  (push_info),
      .pop        (pop),
      .full       (full),
      .empty      (empty),
      .head_flags (head_flags),
      .head_info  (head_info)
   );

   fbds_back #(.MAX_BLOCKS_H(MAX_BLOCKS_H)) u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (empty),
      .head_flags (head_flags),
      .head_info  (head_info),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_stall  (rsp_stall)
   );

endmodule

`default_nettype wire

/* dv/frame_block_diff_spans_test.sv */
// ----------------------------------------------------------------------------
// frame_block_diff_spans_test
// self-checking bench for the changed-block span detector
// ----------------------------------------------------------------------------
// Streams byte pairs of small frames through the block under several frame
// and block geometries, predicts every span and frame-done marker in step
// with each accepted item and compares the result stream field by field.
// Both sides idle at random; one phase holds the result side off for long
// enough that the row queue fills and the input stalls.
`default_nettype none

module frame_block_diff_spans_test;
   import fbds_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_COLS   = 64;
   localparam int NUM_CELLS  = 1024;
   localparam int QUIET_GAP  = 150;   // back end may still walk a row with no spans
   localparam int STALL_LIMIT = 5000;
   localparam int LONG_HOLD  = 600;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;
   logic    req_valid = 1'b0;
   req_type req_data = '0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    rsp_stall = 1'b0;

   frame_block_diff_spans dut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_data(req_data), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .rsp_stall(rsp_stall)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // predictor state: register copies and raster position
   // ---------------------------------------------------------------------
   logic [10:0] reg_w = RST_WIDTH_CELLS;
   logic [10:0] reg_h = RST_HEIGHT_CELLS;
   logic [6:0]  reg_bw = RST_BLOCK_WIDTH;
   logic [6:0]  reg_bh = RST_BLOCK_HEIGHT;
   logic [2:0]  reg_cb = RST_CELL_BYTES;

   logic [NUM_COLS-1:0] dirty = '0;
   int  byte_pos, cell_col, cell_row, col_in_blk, row_in_blk, blk_col, blk_row;
   bit  frame_over = 1'b0;

   rsp_type expected_spans[$];
   req_type pending_bytes[$];

   int errors = 0;
   int bytes_taken = 0, spans_seen = 0, frames_seen = 0, phases_run = 0;
   int gap_max = 0;
   int hold_req = 0;

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, spans_seen);
      errors++;
   endtask

   function automatic int clip(input int v, input int hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void clear_raster();
      dirty = '0;
      byte_pos = 0; cell_col = 0; cell_row = 0;
      col_in_blk = 0; row_in_blk = 0; blk_col = 0; blk_row = 0;
   endfunction

   // every maximal run of dirty block columns, left to right
   function automatic void push_spans(input int w, input int bw, input int cb, input int rows);
      int nb, i, s, n, sw;
      rsp_type r;
      nb = (w + bw - 1) / bw;
      if (nb > NUM_COLS) nb = NUM_COLS;
      i = 0;
      while (i < nb) begin
         if (!dirty[i]) begin
            i++;
         end else begin
            s = i;
            while (i < nb && dirty[i]) i++;
            n = i - s;
            sw = (i == nb) ? w - s * bw : n * bw;
            if (sw > w - s * bw) sw = w - s * bw;
            r = '0;
            r.span_col = s[5:0];
            r.span_row = blk_row[9:0];
            r.span_blocks = n[6:0];
            r.span_width = sw[10:0];
            r.span_height = rows[6:0];
            r.payload_bytes = 19'(sw * rows * cb);
            expected_spans.push_back(r);
         end
      end
   endfunction

   function automatic void track_raster(input req_type b);
      int w, h, bw, bh, cb, before_n;
      rsp_type r;
      w = clip(reg_w, NUM_CELLS);
      h = clip(reg_h, NUM_CELLS);
      bw = clip(reg_bw, 64);
      bh = clip(reg_bh, 64);
      cb = clip(reg_cb, 4);
      before_n = expected_spans.size();
      if (b.frame_start) begin
         clear_raster();
         frame_over = 1'b0;
      end
      if (frame_over) return;
      if (b.prev_byte != b.curr_byte) dirty[blk_col < NUM_COLS ? blk_col : NUM_COLS - 1] = 1'b1;
      if (byte_pos + 1 < cb) begin
         byte_pos++;
         return;
      end
      byte_pos = 0;
      if (col_in_blk + 1 >= bw) begin
         col_in_blk = 0;
         if (blk_col + 1 < NUM_COLS) blk_col++;
      end else begin
         col_in_blk++;
      end
      if (cell_col + 1 < w) begin
         cell_col++;
         return;
      end
      cell_col = 0; col_in_blk = 0; blk_col = 0;
      // end of a cell row: maybe end of a block row too
      if (row_in_blk + 1 >= bh || cell_row + 1 >= h) begin
         push_spans(w, bw, cb, row_in_blk + 1);
         dirty = '0;
         row_in_blk = 0;
         blk_row = (blk_row + 1) % 1024;
      end else begin
         row_in_blk++;
      end
      if (cell_row + 1 >= h) begin
         r = '0;
         r.frame_done = 1'b1;
         expected_spans.push_back(r);
         clear_raster();
         frame_over = 1'b1;
      end else begin
         cell_row++;
      end
      if (expected_spans.size() > before_n) begin
         r = expected_spans.pop_back();
         r.last = 1'b1;
         expected_spans.push_back(r);
      end
   endfunction

   // ---------------------------------------------------------------------
   // sender: one item per handshake, random gap after each
   // ---------------------------------------------------------------------
   int send_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
      end else if (req_valid && req_stall) begin
         // payload held while stalled
      end else if (send_gap > 0) begin
         req_valid <= 1'b0;
         send_gap <= send_gap - 1;
      end else if (pending_bytes.size() > 0) begin
         req_data <= pending_bytes.pop_front();
         req_valid <= 1'b1;
         send_gap <= $urandom_range(0, gap_max);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // receiver: random stall per result, plus one long hold on request
   // ---------------------------------------------------------------------
   int stall_left = 0, stall_max = 18, hold_seen = 0, rsp_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         stall_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         rsp_count <= rsp_count + 1;
         // alternate stretches of heavy and no back-pressure
         if (rsp_count % 40 == 39) stall_max <= ($urandom_range(0, 1) != 0) ? 18 : 0;
         stall_left <= $urandom_range(0, stall_max);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // monitor: predict on accepted input, check on accepted result
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            track_raster(req_data);
            bytes_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_spans.size() == 0) begin
               $display("unexpected result: %p", rsp_data);
               errors++;
            end else begin
               want = expected_spans.pop_front();
               if (rsp_data.span_col != want.span_col)
                  report("span_col", rsp_data.span_col, want.span_col);
               if (rsp_data.span_row != want.span_row)
                  report("span_row", rsp_data.span_row, want.span_row);
               if (rsp_data.span_blocks != want.span_blocks)
                  report("span_blocks", rsp_data.span_blocks, want.span_blocks);
               if (rsp_data.span_width != want.span_width)
                  report("span_width", rsp_data.span_width, want.span_width);
               if (rsp_data.span_height != want.span_height)
                  report("span_height", rsp_data.span_height, want.span_height);
               if (rsp_data.payload_bytes != want.payload_bytes)
                  report("payload_bytes", rsp_data.payload_bytes, want.payload_bytes);
               if (rsp_data.frame_done != want.frame_done)
                  report("frame_done", rsp_data.frame_done, want.frame_done);
               if (rsp_data.last != want.last)
                  report("last", rsp_data.last, want.last);
               if (want.frame_done) frames_seen++;
            end
            spans_seen++;
         end
      end
   end

   // watchdog on cycles with no handshake of any kind
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", quiet_cycles);
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   task automatic write_regs(input int w, input int h, input int bw, input int bh,
                             input int cb);
      logic [CSR_DATA_W-1:0] vals[5];
      logic [CSR_INDEX_W-1:0] idx[5];
      vals = '{CSR_DATA_W'(w), CSR_DATA_W'(h), CSR_DATA_W'(bw), CSR_DATA_W'(bh),
               CSR_DATA_W'(cb)};
      idx = '{REG_WIDTH_CELLS, REG_HEIGHT_CELLS, REG_BLOCK_WIDTH, REG_BLOCK_HEIGHT,
              REG_CELL_BYTES};
      for (int i = 0; i < 5; i++) begin
         @(posedge clock);
         csr_write <= 1'b1;
         csr_index <= idx[i];
         csr_data <= vals[i];
      end
      @(posedge clock);
      csr_write <= 1'b0;
      reg_w = w[10:0];
      reg_h = h[10:0];
      reg_bw = bw[6:0];
      reg_bh = bh[6:0];
      reg_cb = cb[2:0];
   endtask

   // one frame of byte pairs; cut > 0 stops after that many bytes
   task automatic queue_frame(input bit flag_start, input int change_pct, input int cut);
      int n;
      req_type b;
      n = clip(reg_w, NUM_CELLS) * clip(reg_h, NUM_CELLS) * clip(reg_cb, 4);
      if (cut > 0 && cut < n) n = cut;
      for (int i = 0; i < n; i++) begin
         b.prev_byte = 8'($urandom_range(0, 255));
         b.curr_byte = ($urandom_range(1, 100) <= change_pct) ? 8'($urandom_range(0, 255))
                                                                : b.prev_byte;
         b.frame_start = (i == 0) && flag_start;
         pending_bytes.push_back(b);
      end
   endtask

   task automatic queue_stray(input int n);
      req_type b;
      for (int i = 0; i < n; i++) begin
         b.prev_byte = 8'($urandom_range(0, 255));
         b.curr_byte = 8'($urandom_range(0, 255));
         b.frame_start = 1'b0;
         pending_bytes.push_back(b);
      end
   endtask

   // wait for the input queue and all results to drain, then let the back end settle
   task automatic drain();
      while (pending_bytes.size() > 0 || req_valid || expected_spans.size() > 0)
         @(posedge clock);
      repeat (QUIET_GAP) @(posedge clock);
      phases_run++;
   endtask

   initial begin
      int budget, cut;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: first frame straight after reset without a start flag
      write_regs(3, 2, 1, 1, 1);
      gap_max = 0;
      queue_frame(1'b0, 100, 0);
      // bytes after frame end are ignored
      queue_stray(2);
      // fully unchanged frame, then extremes of both bytes
      queue_frame(1'b1, 0, 0);
      pending_bytes.push_back('{8'hFF, 8'h00, 1'b1});
      pending_bytes.push_back('{8'h00, 8'hFF, 1'b0});
      // restart mid-frame
      pending_bytes.push_back('{8'hAA, 8'h55, 1'b1});
      queue_frame(1'b1, 50, 0);
      drain();

      // zero registers count as one: every byte is a frame
      write_regs(0, 0, 0, 0, 0);
      gap_max = 4;
      queue_frame(1'b1, 100, 0);
      queue_frame(1'b1, 0, 0);
      queue_stray(1);
      queue_frame(1'b1, 100, 0);
      drain();

      // oversize block width counts as 64, last block clipped at the edge
      write_regs(130, 1, 127, 1, 1);
      gap_max = 0;
      queue_frame(1'b1, 2, 0);
      drain();

      // more block columns than flags: extra columns fold into the last one
      write_regs(70, 1, 1, 127, 1);
      queue_frame(1'b1, 3, 0);
      drain();

      // tall narrow frame, bottom block row clipped
      write_regs(1, 70, 1, 64, 1);
      gap_max = 18;
      queue_frame(1'b1, 30, 0);
      drain();

      // result side held off while rows keep arriving back to back
      write_regs(8, 4, 1, 1, 1);
      gap_max = 0;
      hold_req = hold_req + 1;
      queue_frame(1'b1, 40, 0);
      queue_frame(1'b1, 40, 0);
      drain();

      // random geometries, mostly whole frames with some noise
      budget = 0;
      while (budget < 150) begin
         write_regs($urandom_range(1, 6), $urandom_range(1, 4),
                    ($urandom_range(0, 9) == 0) ? 70 : $urandom_range(0, 5),
                    $urandom_range(0, 4), $urandom_range(0, 5));
         case ($urandom_range(0, 2))
            0: gap_max = 0;
            1: gap_max = 4;
            default: gap_max = 18;
         endcase
         for (int f = 0; f < 4; f++) begin
            cut = ($urandom_range(0, 9) == 0)
                  ? $urandom_range(1, clip(reg_w, NUM_CELLS) * clip(reg_cb, 4) + 1) : 0;
            queue_frame(1'b1, ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(0, 40), cut);
            if ($urandom_range(0, 9) == 0) queue_stray($urandom_range(1, 3));
         end
         budget += pending_bytes.size();
         drain();
      end

      if (expected_spans.size() > 0) begin
         $display("%0d results never arrived", expected_spans.size());
         errors++;
      end
      $display("covered %0d phases, %0d bytes accepted, %0d results checked, %0d frames",
               phases_run, bytes_taken, spans_seen, frames_seen);
      $display("mismatches: %0d", errors);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
rtl/fbds_pkg.sv
rtl/fbds_front.sv
rtl/fbds_queue.sv
rtl/fbds_back.sv
rtl/frame_block_diff_spans.sv
dv/frame_block_diff_spans_test.sv
